[rtl/pec_pkg.sv]
// Package for the pair elastic collision block: fixed field widths,
// velocity lane indexes and queue sizing. No dependencies.
`default_nettype none

package pec_pkg;

    localparam int MASS_BITS   = 16;
    localparam int RAD_BITS    = 16;
    localparam int MSUM_BITS   = 17;

    localparam int LANES       = 4;
    localparam int LANE_V1X    = 0;
    localparam int LANE_V1Y    = 1;
    localparam int LANE_V2X    = 2;
    localparam int LANE_V2Y    = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    typedef logic [MASS_BITS-1:0] t_mass;
    typedef logic [RAD_BITS-1:0]  t_rad;

endpackage

`default_nettype wire

[rtl/pec_if.sv]
// Handshake interfaces for particle pair items and collision result items.
// Depends on pec_pkg.
`default_nettype none

interface pec_pair_if import pec_pkg::*; #(parameter int COORD_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] first_pos_x;
    logic signed [COORD_BITS-1:0] first_pos_y;
    logic signed [COORD_BITS-1:0] first_vel_x;
    logic signed [COORD_BITS-1:0] first_vel_y;
    logic signed [COORD_BITS-1:0] second_pos_x;
    logic signed [COORD_BITS-1:0] second_pos_y;
    logic signed [COORD_BITS-1:0] second_vel_x;
    logic signed [COORD_BITS-1:0] second_vel_y;
    t_mass                        first_mass;
    t_mass                        second_mass;
    t_rad                         first_radius;
    t_rad                         second_radius;

    modport source (
        output valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y,
               second_pos_x, second_pos_y, second_vel_x, second_vel_y,
               first_mass, second_mass, first_radius, second_radius,
        input  ready
    );
    modport sink (
        input  valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y,
               second_pos_x, second_pos_y, second_vel_x, second_vel_y,
               first_mass, second_mass, first_radius, second_radius,
        output ready
    );
endinterface

interface pec_res_if #(parameter int COORD_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] new_first_vel_x;
    logic signed [COORD_BITS-1:0] new_first_vel_y;
    logic signed [COORD_BITS-1:0] new_second_vel_x;
    logic signed [COORD_BITS-1:0] new_second_vel_y;
    logic                         in_contact;
    logic                         bounced;

    modport source (
        output valid, new_first_vel_x, new_first_vel_y, new_second_vel_x,
               new_second_vel_y, in_contact, bounced,
        input  ready
    );
    modport sink (
        input  valid, new_first_vel_x, new_first_vel_y, new_second_vel_x,
               new_second_vel_y, in_contact, bounced,
        output ready
    );
endinterface

`default_nettype wire

[rtl/pair_elastic_collision_2d.sv]
// Top level of the 2D elastic collision block for one particle pair.
// Depends on pec_pkg, pec_if, pec_front, pec_fifo and pec_back.
//
// Usage:
//   i_pair takes one particle pair item (positions, velocities, masses,
//   radii); o_res gives one result item per pair, in order: the four new
//   velocities, in_contact and bounced. Both are valid/ready channels; an
//   item moves at a rising edge with valid and ready high.
//   Throughput is one item per cycle while o_res does not stall. The back
//   pipeline is dominated by the restoring divider, one quotient bit per
//   stage over COORD_BITS + 4 stages.
//   The front classifies contact and approach in three stages and feeds a
//   four-entry queue; the back computes the velocity change. When o_res
//   stalls the back holds, the queue fills and then i_pair.ready drops.
//   Synchronous active-low reset empties the pipelines and queue; no
//   clearing pass is needed and items are taken in the first cycle after.
`default_nettype none

module pair_elastic_collision_2d import pec_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pec_pair_if.sink  i_pair,
    pec_res_if.source o_res
);

    localparam int C     = COORD_BITS;
    localparam int DW    = 2*C + 2;
    localparam int REC_W = 10*C + 41;

    logic                  w_f_valid;
    logic signed [C-1:0]   w_f_vel [LANES];
    logic signed [C:0]     w_f_dx, w_f_dy;
    logic signed [2*C+2:0] w_f_dot;
    logic [DW-1:0]         w_f_d2;
    t_mass                 w_f_m1, w_f_m2;
    logic                  w_f_contact, w_f_bounce;

    logic                  w_q_full, w_q_valid, w_q_pop;
    logic [REC_W-1:0]      w_q_in, w_q_out;

    logic signed [C-1:0]   w_b_vel [LANES];
    logic signed [C:0]     w_b_dx, w_b_dy;
    logic signed [2*C+2:0] w_b_dot;
    logic [DW-1:0]         w_b_d2;
    t_mass                 w_b_m1, w_b_m2;
    logic                  w_b_contact, w_b_bounce;

    pec_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pair    (i_pair),
        .i_ready   (!w_q_full),
        .o_valid   (w_f_valid),
        .o_vel     (w_f_vel),
        .o_dx      (w_f_dx),
        .o_dy      (w_f_dy),
        .o_dot     (w_f_dot),
        .o_d2      (w_f_d2),
        .o_m1      (w_f_m1),
        .o_m2      (w_f_m2),
        .o_contact (w_f_contact),
        .o_bounce  (w_f_bounce)
    );

    assign w_q_in = {w_f_contact, w_f_bounce, w_f_m1, w_f_m2, w_f_d2, w_f_dot,
                     w_f_dy, w_f_dx, w_f_vel[LANE_V2Y], w_f_vel[LANE_V2X],
                     w_f_vel[LANE_V1Y], w_f_vel[LANE_V1X]};

    pec_fifo #(.WIDTH(REC_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid && !w_q_full),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_out)
    );

    assign {w_b_contact, w_b_bounce, w_b_m1, w_b_m2, w_b_d2, w_b_dot,
            w_b_dy, w_b_dx, w_b_vel[LANE_V2Y], w_b_vel[LANE_V2X],
            w_b_vel[LANE_V1Y], w_b_vel[LANE_V1X]} = w_q_out;

    pec_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_q_valid),
        .o_pop     (w_q_pop),
        .i_vel     (w_b_vel),
        .i_dx      (w_b_dx),
        .i_dy      (w_b_dy),
        .i_dot     (w_b_dot),
        .i_d2      (w_b_d2),
        .i_m1      (w_b_m1),
        .i_m2      (w_b_m2),
        .i_contact (w_b_contact),
        .i_bounce  (w_b_bounce),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire

[rtl/pec_front.sv]
// Front pipeline: differences, squares and dot product, contact and bounce
// classification. Depends on pec_pkg and pec_if.
`default_nettype none

module pec_front import pec_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pec_pair_if.sink                       i_pair,
    input  logic                           i_ready,
    output logic                           o_valid,
    output logic signed [COORD_BITS-1:0]   o_vel [LANES],
    output logic signed [COORD_BITS:0]     o_dx,
    output logic signed [COORD_BITS:0]     o_dy,
    output logic signed [2*COORD_BITS+2:0] o_dot,
    output logic [2*COORD_BITS+1:0]        o_d2,
    output t_mass                          o_m1,
    output t_mass                          o_m2,
    output logic                           o_contact,
    output logic                           o_bounce
);

    localparam int C  = COORD_BITS;
    localparam int DW = 2*C + 2;

    logic w_en;

    logic                   r1_vld;
    logic signed [C+1:0]    r1_px, r1_py;
    logic signed [C:0]      r1_dx, r1_dy, r1_dvx, r1_dvy;
    logic [MSUM_BITS-1:0]   r1_rs;
    logic signed [C-1:0]    r1_vel [LANES];
    t_mass                  r1_m1, r1_m2;

    logic                   r2_vld;
    logic signed [2*C+3:0]  r2_sqx, r2_sqy;
    logic signed [2*C+1:0]  r2_tx, r2_ty, r2_dx2, r2_dy2;
    logic [2*MSUM_BITS-1:0] r2_rad2;
    logic signed [C:0]      r2_dx, r2_dy;
    logic signed [C-1:0]    r2_vel [LANES];
    t_mass                  r2_m1, r2_m2;

    logic                   r3_vld;

    logic signed [C+1:0]    n_px, n_py;
    logic signed [C:0]      n_dx, n_dy, n_dvx, n_dvy;
    logic [MSUM_BITS-1:0]   n_rs;
    logic signed [2*C+3:0]  n_sqx, n_sqy;
    logic signed [2*C+1:0]  n_tx, n_ty, n_dx2, n_dy2;
    logic [2*MSUM_BITS-1:0] n_rad2;
    logic [2*C+4:0]         n_dist2;
    logic signed [2*C+2:0]  n_dot;
    logic [DW-1:0]          n_d2;
    logic                   n_contact;

    assign w_en         = !r3_vld || i_ready;
    assign i_pair.ready = w_en;
    assign o_valid      = r3_vld;

    assign n_px = (C+2)'(i_pair.first_pos_x) + (C+2)'(i_pair.first_vel_x)
                - (C+2)'(i_pair.second_pos_x) - (C+2)'(i_pair.second_vel_x);
    assign n_py = (C+2)'(i_pair.first_pos_y) + (C+2)'(i_pair.first_vel_y)
                - (C+2)'(i_pair.second_pos_y) - (C+2)'(i_pair.second_vel_y);
    assign n_dx  = (C+1)'(i_pair.first_pos_x) - (C+1)'(i_pair.second_pos_x);
    assign n_dy  = (C+1)'(i_pair.first_pos_y) - (C+1)'(i_pair.second_pos_y);
    assign n_dvx = (C+1)'(i_pair.first_vel_x) - (C+1)'(i_pair.second_vel_x);
    assign n_dvy = (C+1)'(i_pair.first_vel_y) - (C+1)'(i_pair.second_vel_y);
    assign n_rs  = MSUM_BITS'(i_pair.first_radius) + MSUM_BITS'(i_pair.second_radius);

    assign n_sqx  = r1_px * r1_px;
    assign n_sqy  = r1_py * r1_py;
    assign n_tx   = r1_dvx * r1_dx;
    assign n_ty   = r1_dvy * r1_dy;
    assign n_dx2  = r1_dx * r1_dx;
    assign n_dy2  = r1_dy * r1_dy;
    assign n_rad2 = r1_rs * r1_rs;

    assign n_dist2   = (2*C+5)'(unsigned'(r2_sqx)) + (2*C+5)'(unsigned'(r2_sqy));
    assign n_contact = n_dist2 <= (2*C+5)'(r2_rad2);
    assign n_dot     = (2*C+3)'(r2_tx) + (2*C+3)'(r2_ty);
    assign n_d2      = DW'(unsigned'(r2_dx2)) + DW'(unsigned'(r2_dy2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_pair.valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;

            r1_px  <= n_px;
            r1_py  <= n_py;
            r1_dx  <= n_dx;
            r1_dy  <= n_dy;
            r1_dvx <= n_dvx;
            r1_dvy <= n_dvy;
            r1_rs  <= n_rs;
            r1_vel[LANE_V1X] <= i_pair.first_vel_x;
            r1_vel[LANE_V1Y] <= i_pair.first_vel_y;
            r1_vel[LANE_V2X] <= i_pair.second_vel_x;
            r1_vel[LANE_V2Y] <= i_pair.second_vel_y;
            r1_m1  <= i_pair.first_mass;
            r1_m2  <= i_pair.second_mass;

            r2_sqx  <= n_sqx;
            r2_sqy  <= n_sqy;
            r2_tx   <= n_tx;
            r2_ty   <= n_ty;
            r2_dx2  <= n_dx2;
            r2_dy2  <= n_dy2;
            r2_rad2 <= n_rad2;
            r2_dx   <= r1_dx;
            r2_dy   <= r1_dy;
            r2_vel  <= r1_vel;
            r2_m1   <= r1_m1;
            r2_m2   <= r1_m2;

            o_vel     <= r2_vel;
            o_dx      <= r2_dx;
            o_dy      <= r2_dy;
            o_dot     <= n_dot;
            o_d2      <= n_d2;
            o_m1      <= r2_m1;
            o_m2      <= r2_m2;
            o_contact <= n_contact;
            o_bounce  <= n_contact && n_dot[2*C+2] && ((r2_m1 != '0) || (r2_m2 != '0));
        end
    end

endmodule

`default_nettype wire

[rtl/pec_fifo.sv]
// Short queue of classified items between front and back.
// Depends on pec_pkg.
`default_nettype none

module pec_fifo import pec_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0]     r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr, r_rd;
    logic [QCNT_BITS-1:0] r_cnt;

    assign o_full  = r_cnt == QCNT_BITS'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_data;
                r_wr        <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/pec_back.sv]
// Back pipeline: velocity change numerators, pipelined restoring division,
// rounding, saturation and the output register. Depends on pec_pkg, pec_if.
`default_nettype none

module pec_back import pec_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_pop,
    input  logic signed [COORD_BITS-1:0]   i_vel [LANES],
    input  logic signed [COORD_BITS:0]     i_dx,
    input  logic signed [COORD_BITS:0]     i_dy,
    input  logic signed [2*COORD_BITS+2:0] i_dot,
    input  logic [2*COORD_BITS+1:0]        i_d2,
    input  t_mass                          i_m1,
    input  t_mass                          i_m2,
    input  logic                           i_contact,
    input  logic                           i_bounce,
    pec_res_if.source                      o_res
);

    localparam int C    = COORD_BITS;
    localparam int DW   = 2*C + 2;
    localparam int H    = C + 1;
    localparam int HW   = DW - H;
    localparam int AW   = C + 1 + MSUM_BITS;
    localparam int DENW = DW + MSUM_BITS;
    localparam int QB   = C + 4;
    localparam int RW   = DENW + QB;
    localparam int SW   = QB + 2;

    logic w_en;

    // numerator factors
    logic                      r1_vld;
    logic [AW-1:0]             r1_a [LANES];
    logic [DW-1:0]             r1_dm;
    logic [H+MSUM_BITS-1:0]    r1_dplo;
    logic [HW+MSUM_BITS-1:0]   r1_dphi;
    logic                      r1_add [LANES];
    logic signed [C-1:0]       r1_vel [LANES];
    logic                      r1_contact, r1_bounce;

    // partial products
    logic                      r2_vld;
    logic [H+AW-1:0]           r2_plo [LANES];
    logic [HW+AW-1:0]          r2_phi [LANES];
    logic [DENW-1:0]           r2_den;
    logic                      r2_add [LANES];
    logic signed [C-1:0]       r2_vel [LANES];
    logic                      r2_contact, r2_bounce;

    // divider stages
    logic [RW-1:0]             r_rem [LANES][QB+1];
    logic [QB-1:0]             r_q   [LANES][QB+1];
    logic [DENW-1:0]           r_den [QB+1];
    logic                      r_dv_vld [QB+1];
    logic                      r_dv_add [LANES][QB+1];
    logic signed [C-1:0]       r_dv_vel [LANES][QB+1];
    logic                      r_dv_contact [QB+1];
    logic                      r_dv_bounce [QB+1];

    logic [RW-1:0]             n_rem [LANES][QB+1];
    logic [QB-1:0]             n_q   [LANES][QB+1];

    // rounding
    logic                      r_rd_vld;
    logic [QB-1:0]             r_rd_q [LANES];
    logic                      r_rd_add [LANES];
    logic signed [C-1:0]       r_rd_vel [LANES];
    logic                      r_rd_contact, r_rd_bounce;

    // output
    logic                      r_out_vld;
    logic signed [C-1:0]       r_out_vel [LANES];
    logic                      r_out_contact, r_out_bounce;

    logic [C:0]                n_adx, n_ady;
    logic [MSUM_BITS-1:0]      n_tm1, n_tm2, n_msum;
    logic [AW-1:0]             n_a [LANES];
    logic [DENW-1:0]           n_den;
    logic [QB-1:0]             n_rd_q [LANES];
    logic signed [C-1:0]       n_out_vel [LANES];

    assign w_en  = !r_out_vld || o_res.ready;
    assign o_pop = w_en && i_valid;

    assign n_adx  = i_dx[C] ? unsigned'(-i_dx) : unsigned'(i_dx);
    assign n_ady  = i_dy[C] ? unsigned'(-i_dy) : unsigned'(i_dy);
    assign n_tm1  = {i_m1, 1'b0};
    assign n_tm2  = {i_m2, 1'b0};
    assign n_msum = MSUM_BITS'(i_m1) + MSUM_BITS'(i_m2);

    assign n_a[LANE_V1X] = n_tm2 * n_adx;
    assign n_a[LANE_V1Y] = n_tm2 * n_ady;
    assign n_a[LANE_V2X] = n_tm1 * n_adx;
    assign n_a[LANE_V2Y] = n_tm1 * n_ady;

    assign n_den = DENW'(r1_dplo) + (DENW'(r1_dphi) << H);

    always_comb begin
        logic [RW-1:0] sub;
        logic          ge;
        sub = '0;
        ge  = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            n_rem[l][0] = RW'(r2_plo[l]) + (RW'(r2_phi[l]) << H);
            n_q[l][0]   = '0;
            for (int k = 0; k < QB; k++) begin
                sub = RW'(r_den[k]) << (QB-1-k);
                ge  = r_rem[l][k] >= sub;
                n_rem[l][k+1] = ge ? r_rem[l][k] - sub : r_rem[l][k];
                n_q[l][k+1]   = r_q[l][k] | (ge ? (QB'(1) << (QB-1-k)) : '0);
            end
        end
    end

    always_comb begin
        logic [DENW:0] twice_r;
        twice_r = '0;
        for (int l = 0; l < LANES; l++) begin
            twice_r   = {r_rem[l][QB][DENW-1:0], 1'b0};
            n_rd_q[l] = r_q[l][QB] + QB'(twice_r >= {1'b0, r_den[QB]});
        end
    end

    always_comb begin
        logic signed [SW-1:0] v;
        logic signed [SW-1:0] q;
        logic signed [SW-1:0] s;
        logic [SW-C:0]        top;
        v   = '0;
        q   = '0;
        s   = '0;
        top = '0;
        for (int l = 0; l < LANES; l++) begin
            v   = SW'(r_rd_vel[l]);
            q   = signed'({2'b00, r_rd_q[l]});
            s   = r_rd_add[l] ? v + q : v - q;
            top = s[SW-1:C-1];
            if (!r_rd_bounce) begin
                n_out_vel[l] = r_rd_vel[l];
            end else if ((top != '0) && (top != '1)) begin
                n_out_vel[l] = s[SW-1] ? signed'({1'b1, {(C-1){1'b0}}})
                                       : signed'({1'b0, {(C-1){1'b1}}});
            end else begin
                n_out_vel[l] = s[C-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k <= QB; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r1_vld     <= i_valid;
            r1_a       <= n_a;
            r1_dm      <= DW'(unsigned'(-i_dot));
            r1_dplo    <= i_d2[H-1:0] * n_msum;
            r1_dphi    <= i_d2[DW-1:H] * n_msum;
            r1_add[LANE_V1X] <= !i_dx[C];
            r1_add[LANE_V1Y] <= !i_dy[C];
            r1_add[LANE_V2X] <= i_dx[C];
            r1_add[LANE_V2Y] <= i_dy[C];
            r1_vel     <= i_vel;
            r1_contact <= i_contact;
            r1_bounce  <= i_bounce;

            r2_vld <= r1_vld;
            for (int l = 0; l < LANES; l++) begin
                r2_plo[l] <= r1_dm[H-1:0] * r1_a[l];
                r2_phi[l] <= r1_dm[DW-1:H] * r1_a[l];
            end
            r2_den     <= n_den;
            r2_add     <= r1_add;
            r2_vel     <= r1_vel;
            r2_contact <= r1_contact;
            r2_bounce  <= r1_bounce;

            r_dv_vld[0]     <= r2_vld;
            r_den[0]        <= r2_den;
            r_dv_contact[0] <= r2_contact;
            r_dv_bounce[0]  <= r2_bounce;
            for (int l = 0; l < LANES; l++) begin
                r_dv_add[l][0] <= r2_add[l];
                r_dv_vel[l][0] <= r2_vel[l];
            end
            for (int k = 0; k < QB; k++) begin
                r_dv_vld[k+1]     <= r_dv_vld[k];
                r_den[k+1]        <= r_den[k];
                r_dv_contact[k+1] <= r_dv_contact[k];
                r_dv_bounce[k+1]  <= r_dv_bounce[k];
                for (int l = 0; l < LANES; l++) begin
                    r_dv_add[l][k+1] <= r_dv_add[l][k];
                    r_dv_vel[l][k+1] <= r_dv_vel[l][k];
                end
            end
            r_rem <= n_rem;
            r_q   <= n_q;

            r_rd_vld     <= r_dv_vld[QB];
            r_rd_q       <= n_rd_q;
            r_rd_contact <= r_dv_contact[QB];
            r_rd_bounce  <= r_dv_bounce[QB];
            for (int l = 0; l < LANES; l++) begin
                r_rd_add[l] <= r_dv_add[l][QB];
                r_rd_vel[l] <= r_dv_vel[l][QB];
            end

            r_out_vld     <= r_rd_vld;
            r_out_vel     <= n_out_vel;
            r_out_contact <= r_rd_contact;
            r_out_bounce  <= r_rd_bounce;
        end
    end

    assign o_res.valid            = r_out_vld;
    assign o_res.new_first_vel_x  = r_out_vel[LANE_V1X];
    assign o_res.new_first_vel_y  = r_out_vel[LANE_V1Y];
    assign o_res.new_second_vel_x = r_out_vel[LANE_V2X];
    assign o_res.new_second_vel_y = r_out_vel[LANE_V2Y];
    assign o_res.in_contact       = r_out_contact;
    assign o_res.bounced          = r_out_bounce;

endmodule

`default_nettype wire
